FILE: src/afa_pkg.sv
`timescale 1ns / 1ps

package afa_pkg;

  // Item codes on the byte channel
  localparam logic ACT_DRDY = 1'b0;  // data-ready event, restarts the frame
  localparam logic ACT_BYTE = 1'b1;  // one received converter byte

  // Frame layout: byte index at which each byte arrives
  localparam logic [2:0] POS_LOW    = 3'd1;
  localparam logic [2:0] POS_HIGH   = 3'd2;
  localparam logic [2:0] POS_MID    = 3'd3;
  localparam logic [2:0] POS_STATUS = 3'd4;
  localparam logic [2:0] FRAME_LEN  = 3'd5;

  // Status byte bit that flags a converter fault
  localparam int FAULT_BIT = 5;

  // Moving average window and ring defaults
  localparam int WINDOW_LEN         = 16;
  localparam int RING_DEPTH_DEFAULT = 16;
  localparam int ENTRY_W            = 24;

  // Scale register reset, about 0.000287451 in Q0.32
  localparam logic [31:0] SCALE_RESET = 32'd1234593;

  // Saturation limits of the 21-bit weight, as magnitudes
  localparam logic [31:0] WEIGHT_NEG_LIMIT = 32'd1048576;
  localparam logic [31:0] WEIGHT_POS_LIMIT = 32'd1048575;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } byte_item_t;

  typedef struct packed {
    logic               sample_done;
    logic signed [31:0] raw_sample;
    logic signed [20:0] filtered_weight;
    logic               fault_flag;
    logic        [31:0] sample_total;
  } result_item_t;

endpackage

FILE: src/bridge_adc_frame_averager_core.sv
`timescale 1ns / 1ps

// Bridge converter frame reader with a sixteen-sample moving average. One item
// is accepted every cycle while byte_stall is low; each accepted item gives
// exactly one result, registered in turn through frame state update, sum
// magnitude, 32x32 scale multiply and saturation into the result register.
// Items that keep arriving while the result side stalls fill the empty
// pipeline stages before byte_stall rises. The sample ring lives in a RAM of
// RING_DEPTH entries read ahead of use; it has no clearing pass, a fill count
// of the first sixteen stores stands in for the zeroed entries, so the block
// is ready right after reset. cfg_data sets the Q0.32 weight scale, which the
// user must have written only while idle; the block itself does not enforce it.
module bridge_adc_frame_averager_core #(
  parameter int RING_DEPTH = afa_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  afa_pkg::byte_item_t   byte_item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output afa_pkg::result_item_t result_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [31:0]           cfg_data
);

  localparam int PW  = $clog2(RING_DEPTH);
  localparam int EW  = afa_pkg::ENTRY_W;
  localparam int FCW = $clog2(afa_pkg::WINDOW_LEN + 1);
  localparam logic [PW:0]    LEAVE_OFS = (PW + 1)'(RING_DEPTH - afa_pkg::WINDOW_LEN);
  localparam logic [PW:0]    DEPTH_W   = (PW + 1)'(RING_DEPTH);
  localparam logic [PW-1:0]  PTR_LAST  = PW'(RING_DEPTH - 1);
  localparam logic [FCW-1:0] FILL_FULL = FCW'(afa_pkg::WINDOW_LEN);

  typedef struct packed {
    logic        done;
    logic [31:0] raw;
    logic        fault;
    logic [31:0] total;
  } common_t;

  // Configuration register
  logic [31:0] weight_scale;

  // Frame and filter state
  logic [2:0]     byte_index, byte_index_next;
  logic [7:0]     byte_low, byte_high, byte_mid;
  logic [PW-1:0]  ring_pointer, ring_pointer_next;
  logic [FCW-1:0] fill_count, fill_count_next;
  logic [31:0]    window_sum, window_sum_next;
  logic           fault_latch, fault_latch_next;
  logic [31:0]    sample_counter, sample_counter_next;
  logic [EW-1:0]  last_entry, last_entry_next;

  logic           byte_accept;
  logic           store;
  logic [EW-1:0]  new_entry;
  logic [EW-1:0]  leave_entry;
  logic [EW-1:0]  ram_rdata;
  logic [PW:0]    leave_sum;
  logic [PW-1:0]  leave_addr;

  // Pipeline stages
  logic        s1_valid, s2_valid, s3_valid;
  common_t     s1_com, s2_com, s3_com;
  logic [31:0] s1_sum;
  logic        s2_neg, s3_neg;
  logic [31:0] s2_mag, s3_prod;
  logic [63:0] product;
  logic        ld_out, ld3, ld2, ld1;
  logic [31:0] sat_mag;
  logic [20:0] weight;

  // Stage enables: a stage loads when empty or when it drains this cycle
  assign ld_out      = !result_valid || !result_stall;
  assign ld3         = !s3_valid || ld_out;
  assign ld2         = !s2_valid || ld3;
  assign ld1         = !s1_valid || ld2;
  assign byte_stall  = !ld1;
  assign byte_accept = byte_valid && !byte_stall;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_scale <= afa_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      weight_scale <= cfg_data;
    end
  end

  // Frame sequencing
  always_comb begin
    byte_index_next = byte_index;
    store           = 1'b0;
    if (byte_accept) begin
      if (byte_item.action == afa_pkg::ACT_DRDY) begin
        byte_index_next = '0;
      end else if (byte_index < afa_pkg::FRAME_LEN) begin
        byte_index_next = byte_index + 3'd1;
        store           = (byte_index == afa_pkg::POS_STATUS);
      end
    end
  end

  // Data bytes of the frame; byte zero carries nothing used
  always_ff @(posedge clk) begin
    if (byte_accept && byte_item.action == afa_pkg::ACT_BYTE) begin
      case (byte_index)
        afa_pkg::POS_LOW:  byte_low  <= byte_item.rx_byte;
        afa_pkg::POS_HIGH: byte_high <= byte_item.rx_byte;
        afa_pkg::POS_MID:  byte_mid  <= byte_item.rx_byte;
        default: ;
      endcase
    end
  end

  // Subtracting 0x80000000 just flips the sample MSB
  assign new_entry = {~byte_high[7], byte_high[6:0], byte_mid, byte_low};

  // Entry leaving the window, sixteen stores back
  assign leave_sum  = {1'b0, ring_pointer} + LEAVE_OFS;
  assign leave_addr = (leave_sum >= DEPTH_W) ? PW'(leave_sum - DEPTH_W) : leave_sum[PW-1:0];

  afa_ram #(
    .WIDTH (EW),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (ring_pointer),
    .wr_data (new_entry),
    .rd_addr (leave_addr),
    .rd_data (ram_rdata)
  );

  // Entries never written read as zero
  assign leave_entry = (fill_count == FILL_FULL) ? ram_rdata : '0;

  // Sample store: sixteenth of an entry is exact, the entry shifted by four
  always_comb begin
    ring_pointer_next   = ring_pointer;
    fill_count_next     = fill_count;
    window_sum_next     = window_sum;
    fault_latch_next    = fault_latch;
    sample_counter_next = sample_counter;
    last_entry_next     = last_entry;
    if (store) begin
      ring_pointer_next   = (ring_pointer == PTR_LAST) ? '0 : ring_pointer + 1'b1;
      fill_count_next     = (fill_count == FILL_FULL) ? fill_count : fill_count + 1'b1;
      window_sum_next     = window_sum
                          - {{4{leave_entry[EW-1]}}, leave_entry, 4'b0}
                          + {{4{new_entry[EW-1]}}, new_entry, 4'b0};
      fault_latch_next    = fault_latch | byte_item.rx_byte[afa_pkg::FAULT_BIT];
      sample_counter_next = sample_counter + 32'd1;
      last_entry_next     = new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index     <= '0;
      ring_pointer   <= '0;
      fill_count     <= '0;
      window_sum     <= '0;
      fault_latch    <= 1'b0;
      sample_counter <= '0;
      last_entry     <= '0;
    end else begin
      byte_index     <= byte_index_next;
      ring_pointer   <= ring_pointer_next;
      fill_count     <= fill_count_next;
      window_sum     <= window_sum_next;
      fault_latch    <= fault_latch_next;
      sample_counter <= sample_counter_next;
      last_entry     <= last_entry_next;
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= byte_accept || (s1_valid && !ld2);
      s2_valid     <= (s1_valid && ld2) || (s2_valid && !ld3);
      s3_valid     <= (s2_valid && ld3) || (s3_valid && !ld_out);
      result_valid <= (s3_valid && ld_out) || (result_valid && result_stall);
    end
  end

  // Stage 1: snapshot of the state after the item
  always_ff @(posedge clk) begin
    if (byte_accept) begin
      s1_com.done  <= store;
      s1_com.raw   <= {last_entry_next, 8'h00};
      s1_com.fault <= fault_latch_next;
      s1_com.total <= sample_counter_next;
      s1_sum       <= window_sum_next;
    end
  end

  // Stage 2: sign and magnitude of the window sum
  always_ff @(posedge clk) begin
    if (s1_valid && ld2) begin
      s2_com <= s1_com;
      s2_neg <= s1_sum[31];
      s2_mag <= s1_sum[31] ? (32'd0 - s1_sum) : s1_sum;
    end
  end

  // Stage 3: Q0.32 scale, keep the integer part
  assign product = {32'd0, s2_mag} * {32'd0, weight_scale};

  always_ff @(posedge clk) begin
    if (s2_valid && ld3) begin
      s3_com  <= s2_com;
      s3_neg  <= s2_neg;
      s3_prod <= product[63:32];
    end
  end

  // Result: saturate to 21 bits and restore the sign
  always_comb begin
    if (s3_neg) begin
      sat_mag = (s3_prod > afa_pkg::WEIGHT_NEG_LIMIT) ? afa_pkg::WEIGHT_NEG_LIMIT : s3_prod;
      weight  = 21'(32'd0 - sat_mag);
    end else begin
      sat_mag = (s3_prod > afa_pkg::WEIGHT_POS_LIMIT) ? afa_pkg::WEIGHT_POS_LIMIT : s3_prod;
      weight  = sat_mag[20:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && ld_out) begin
      result_item.sample_done     <= s3_com.done;
      result_item.raw_sample      <= s3_com.raw;
      result_item.filtered_weight <= weight;
      result_item.fault_flag      <= s3_com.fault;
      result_item.sample_total    <= s3_com.total;
    end
  end

endmodule

FILE: src/afa_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write port, one registered read port
module afa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/afa_checker.sv
`timescale 1ns / 1ps

// Port-level checks of the frame averager
module afa_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  result_valid,
  input logic                  result_stall,
  input afa_pkg::result_item_t result_item
);

  logic        result_take;
  logic        seen;
  logic [31:0] last_total;
  logic [31:0] last_raw;
  logic        last_fault;

  assign result_take = result_valid && !result_stall;

  // Previous delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= 1'b0;
      last_total <= '0;
      last_raw   <= '0;
      last_fault <= 1'b0;
    end else if (result_take) begin
      seen       <= 1'b1;
      last_total <= result_item.sample_total;
      last_raw   <= result_item.raw_sample;
      last_fault <= result_item.fault_flag;
    end
  end

  // Sample count moves by one exactly on completed frames
  a_total_step: assert property (@(posedge clk) disable iff (rst)
    result_take && seen |->
      result_item.sample_total == last_total + {31'd0, result_item.sample_done})
    else $error("sample_total step does not match sample_done");

  // Fault flag is sticky until reset
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    result_take && seen && last_fault |-> result_item.fault_flag)
    else $error("fault_flag cleared without reset");

  // Raw sample changes only with a new frame
  a_raw_hold: assert property (@(posedge clk) disable iff (rst)
    result_take && seen && !result_item.sample_done |-> result_item.raw_sample == last_raw)
    else $error("raw_sample changed without a completed frame");

  // Raw sample low byte is always zero
  a_raw_low: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_item.raw_sample[7:0] == 8'h00)
    else $error("raw_sample low byte not zero");

  // Stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("stalled result item changed");

endmodule

bind bridge_adc_frame_averager_core afa_checker u_afa_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam logic [7:0] FAULT_MASK = 8'(1 << afa_pkg::FAULT_BIT);

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  byte_valid = 1'b0;
  logic                  byte_stall;
  afa_pkg::byte_item_t   byte_item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  afa_pkg::result_item_t result_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [31:0]           cfg_data = '0;

  bridge_adc_frame_averager_core dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // 12 ns clock
  always #6 clk = ~clk;

  // Bytes waiting to be sent and readouts waiting to come back
  afa_pkg::byte_item_t   byte_plan[$];
  afa_pkg::result_item_t readout_due[$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  idle_pct = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  bit  byte_taken = 1'b0;
  bit  fault_allowed = 1'b0;

  // Predictor state
  logic [2:0]  frame_pos;
  logic [7:0]  frame_buf[4];
  logic [23:0] ring_mem[16];
  logic [3:0]  ring_wr;
  logic [31:0] win_sum;
  logic        fault_seen;
  logic [31:0] stored_count;
  logic [31:0] scale_q32;

  // Signed sample of a ring entry, divided by 16 toward zero
  function automatic logic [31:0] entry_sixteenth(logic [23:0] entry);
    logic signed [31:0] v;
    v = {entry, 8'h00};
    return v / 32'sd16;
  endfunction

  // Scaled, saturated weight from the running sum
  function automatic logic [20:0] scaled_weight(logic [31:0] sum, logic [31:0] scale);
    longint      acc;
    logic [63:0] mag;
    logic [63:0] w;
    acc = longint'(signed'(sum));
    mag = (acc < 0) ? 64'(-acc) : 64'(acc);
    w = (mag * 64'(scale)) >> 32;
    if (acc < 0) begin
      if (w > 64'(afa_pkg::WEIGHT_NEG_LIMIT)) w = 64'(afa_pkg::WEIGHT_NEG_LIMIT);
      return 21'(-w);
    end
    if (w > 64'(afa_pkg::WEIGHT_POS_LIMIT)) w = 64'(afa_pkg::WEIGHT_POS_LIMIT);
    return 21'(w);
  endfunction

  // Advance the frame reader by one item and form the readout it gives
  function automatic afa_pkg::result_item_t predict_readout(afa_pkg::byte_item_t it);
    afa_pkg::result_item_t r;
    logic [31:0]           sample;
    logic                  done;
    done = 1'b0;
    if (it.action == afa_pkg::ACT_DRDY) begin
      frame_pos = '0;
    end else if (frame_pos < afa_pkg::FRAME_LEN) begin
      if (frame_pos < afa_pkg::POS_STATUS) frame_buf[frame_pos[1:0]] = it.rx_byte;
      frame_pos = frame_pos + 3'd1;
      if (frame_pos == afa_pkg::FRAME_LEN) begin
        sample = {frame_buf[afa_pkg::POS_HIGH[1:0]], frame_buf[afa_pkg::POS_MID[1:0]],
                  frame_buf[afa_pkg::POS_LOW[1:0]], 8'h00} - 32'h8000_0000;
        // window equals ring depth: the entry leaving is the one overwritten
        win_sum = win_sum - entry_sixteenth(ring_mem[ring_wr]);
        ring_mem[ring_wr] = sample[31:8];
        win_sum = win_sum + entry_sixteenth(ring_mem[ring_wr]);
        ring_wr = ring_wr + 4'd1;
        if (it.rx_byte[afa_pkg::FAULT_BIT]) fault_seen = 1'b1;
        stored_count = stored_count + 32'd1;
        done = 1'b1;
      end
    end
    r.sample_done     = done;
    r.raw_sample      = {ring_mem[ring_wr - 4'd1], 8'h00};
    r.filtered_weight = scaled_weight(win_sum, scale_q32);
    r.fault_flag      = fault_seen;
    r.sample_total    = stored_count;
    return r;
  endfunction

  // Byte driver: holds a stalled item, otherwise sends the next one or idles
  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (byte_valid && !byte_taken) begin
      byte_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap = send_gap - 1;
      byte_valid <= 1'b0;
    end else if (byte_plan.size() > 0) begin
      byte_item <= byte_plan.pop_front();
      byte_valid <= 1'b1;
      if ($urandom_range(0, 99) < idle_pct) send_gap = $urandom_range(1, 18);
    end else begin
      byte_valid <= 1'b0;
    end
    byte_taken = 1'b0;
  end

  // Result-side stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      if (!rst && $urandom_range(0, 99) < idle_pct) stall_left = $urandom_range(1, 18);
    end
  end

  // Byte monitor: each accepted item feeds the predictor
  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) begin
      readout_due.push_back(predict_readout(byte_item));
      byte_taken = 1'b1;
    end
  end

  // Result monitor: compare against the oldest readout due
  always @(posedge clk) begin
    afa_pkg::result_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (readout_due.size() == 0) begin
        $error("unexpected result item: %p", result_item);
        mismatch_count++;
      end else begin
        want = readout_due.pop_front();
        if (result_item.sample_done !== want.sample_done) begin
          $error("sample_done expected %0d got %0d", want.sample_done,
                 result_item.sample_done);
          mismatch_count++;
        end
        if (result_item.raw_sample !== want.raw_sample) begin
          $error("raw_sample expected %0d got %0d", want.raw_sample,
                 result_item.raw_sample);
          mismatch_count++;
        end
        if (result_item.filtered_weight !== want.filtered_weight) begin
          $error("filtered_weight expected %0d got %0d", want.filtered_weight,
                 result_item.filtered_weight);
          mismatch_count++;
        end
        if (result_item.fault_flag !== want.fault_flag) begin
          $error("fault_flag expected %0d got %0d", want.fault_flag,
                 result_item.fault_flag);
          mismatch_count++;
        end
        if (result_item.sample_total !== want.sample_total) begin
          $error("sample_total expected %0d got %0d", want.sample_total,
                 result_item.sample_total);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void queue_byte(logic act, logic [7:0] b);
    afa_pkg::byte_item_t it;
    it.action  = act;
    it.rx_byte = b;
    byte_plan.push_back(it);
  endfunction

  // Data bytes lean toward the extremes so the sum swings hard
  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] status_byte();
    logic [7:0] s;
    s = 8'($urandom) & ~FAULT_MASK;
    if (fault_allowed && $urandom_range(0, 19) == 0) s = s | FAULT_MASK;
    return s;
  endfunction

  // Byte 0, low, high, mid, status
  function automatic void queue_frame(bit with_drdy);
    if (with_drdy) queue_byte(afa_pkg::ACT_DRDY, 8'($urandom));
    queue_byte(afa_pkg::ACT_BYTE, 8'($urandom));
    for (int i = 0; i < 3; i++) queue_byte(afa_pkg::ACT_BYTE, data_byte());
    queue_byte(afa_pkg::ACT_BYTE, status_byte());
  endfunction

  // Mostly clean frames, with trailing bytes, cut frames and strays mixed in
  function automatic void queue_random(int count);
    int start;
    int pick;
    start = byte_plan.size();
    while (byte_plan.size() - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        queue_frame(1'b1);
      end else if (pick < 88) begin
        queue_frame(1'b1);
        repeat ($urandom_range(1, 3)) queue_byte(afa_pkg::ACT_BYTE, 8'($urandom));
      end else if (pick < 95) begin
        queue_byte(afa_pkg::ACT_DRDY, 8'($urandom));
        repeat ($urandom_range(1, 4)) queue_byte(afa_pkg::ACT_BYTE, data_byte());
      end else if (pick < 98) begin
        queue_byte(afa_pkg::ACT_DRDY, 8'($urandom));
      end else begin
        queue_byte(afa_pkg::ACT_BYTE, 8'($urandom));
      end
    end
  endfunction

  // Let the plan drain and every readout come back
  task automatic wait_drained();
    while (byte_plan.size() > 0 || byte_valid || readout_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    scale_q32 = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [31:0] scale, int count, int pct);
    write_scale(scale);
    idle_pct = pct;
    queue_random(count);
    wait_drained();
  endtask

  initial begin
    frame_pos    = '0;
    ring_wr      = '0;
    win_sum      = '0;
    fault_seen   = 1'b0;
    stored_count = '0;
    scale_q32    = afa_pkg::SCALE_RESET;
    for (int i = 0; i < 4; i++) frame_buf[i] = '0;
    for (int i = 0; i < 16; i++) ring_mem[i] = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: frame right after reset with no data-ready, largest sample
    idle_pct = 10;
    queue_byte(afa_pkg::ACT_BYTE, 8'h11);
    queue_byte(afa_pkg::ACT_BYTE, 8'hFF);
    queue_byte(afa_pkg::ACT_BYTE, 8'hFF);
    queue_byte(afa_pkg::ACT_BYTE, 8'hFF);
    queue_byte(afa_pkg::ACT_BYTE, 8'h00);
    // byte past the end of the frame is ignored
    queue_byte(afa_pkg::ACT_BYTE, 8'hAB);
    // smallest sample, data-ready carrying a full byte
    queue_byte(afa_pkg::ACT_DRDY, 8'hFF);
    for (int i = 0; i < 4; i++) queue_byte(afa_pkg::ACT_BYTE, 8'h00);
    queue_byte(afa_pkg::ACT_BYTE, 8'hDF);
    // cut frame, then a restart that forms a zero sample
    queue_byte(afa_pkg::ACT_DRDY, 8'h00);
    queue_byte(afa_pkg::ACT_BYTE, 8'h5A);
    queue_byte(afa_pkg::ACT_BYTE, 8'hA5);
    queue_byte(afa_pkg::ACT_DRDY, 8'h00);
    queue_byte(afa_pkg::ACT_BYTE, 8'h01);
    queue_byte(afa_pkg::ACT_BYTE, 8'h00);
    queue_byte(afa_pkg::ACT_BYTE, 8'h80);
    queue_byte(afa_pkg::ACT_BYTE, 8'h00);
    queue_byte(afa_pkg::ACT_BYTE, 8'h00);
    queue_random(180);
    wait_drained();

    // Scale sweep; the full-scale phase drives the weight into saturation
    run_phase(32'hFFFF_FFFF, 250, 25);
    run_phase(32'h0000_0000, 150, 8);
    fault_allowed = 1'b1;
    run_phase($urandom, 250, 15);
    run_phase(32'h0000_0001, 200, 30);
    // last stretch runs with no idling on either side
    run_phase(afa_pkg::SCALE_RESET, 250, 0);

    if (mismatch_count == 0 && readout_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
